[src/bba_pkg.sv]
package bba_pkg;

    localparam int unsigned BBA_MAX_BLOCKS = 1024;

    localparam int unsigned OP_W   = 2;
    localparam int unsigned IDX_W  = 10;
    localparam int unsigned CNT_W  = 11;
    localparam int unsigned ST_W   = 2;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned APB_DW = 32;
    localparam int unsigned APB_AW = 3;

    localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

    localparam logic [OP_W-1:0] OP_FIND = 2'd0;
    localparam logic [OP_W-1:0] OP_SET  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLR  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_NONE  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic [APB_AW-1:0] REG_BLOCK_COUNT = 3'd0;

    // Bit 7 of a bitmap byte is the lowest block, so the search runs from the top bit.
    function automatic logic [2:0] first_clear(input logic [BYTE_W-1:0] b);
        logic [2:0] pos;
        pos = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            if (!b[i]) begin
                pos = 3'(BYTE_W - 1 - i);
            end
        end
        return pos;
    endfunction

endpackage

[src/bba_if.sv]
interface bba_req_if;
    import bba_pkg::*;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [IDX_W-1:0] block_index;

    modport source (output valid, output opcode, output block_index, input ready);
    modport sink (input valid, input opcode, input block_index, output ready);
endinterface

interface bba_rsp_if;
    import bba_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] found_index;
    logic [ST_W-1:0]  status;

    modport source (output valid, output found_index, output status, input ready);
    modport sink (input valid, input found_index, input status, output ready);
endinterface

[src/bba_ram.sv]
module bba_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/bba_engine.sv]
module bba_engine #(
    parameter int unsigned MAX_BLOCKS = bba_pkg::BBA_MAX_BLOCKS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [bba_pkg::CNT_W-1:0] i_block_count,
    bba_req_if.sink                   i_req,
    bba_rsp_if.source                 o_rsp
);
    import bba_pkg::*;

    localparam int unsigned DEPTH    = (MAX_BLOCKS + 7) / 8;
    localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_MAX  = (1 << CNT_W) - 1;
    localparam int unsigned CAP      = (MAX_BLOCKS < CNT_MAX) ? MAX_BLOCKS : CNT_MAX;
    localparam int unsigned KW       = CNT_W - 3;
    localparam int unsigned SCAN_MAX = (DEPTH < (CNT_MAX >> 3)) ? DEPTH : (CNT_MAX >> 3);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_UPD,
        S_RESP
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0]     r_clr, n_clr;
    logic [KW-1:0]     r_k, n_k;
    logic [KW-1:0]     r_limit, n_limit;
    logic [OP_W-1:0]   r_op, n_op;
    logic [2:0]        r_bit, n_bit;
    logic [AW-1:0]     r_addr, n_addr;
    logic [IDX_W-1:0]  r_res_found, n_res_found;
    logic [ST_W-1:0]   r_res_status, n_res_status;
    logic              r_out_valid, n_out_valid;
    logic [IDX_W-1:0]  r_found, n_found;
    logic [ST_W-1:0]   r_status, n_status;

    logic [CNT_W-1:0]  eff_count;
    logic [KW-1:0]     scan_bytes;
    logic [KW-1:0]     scan_limit;
    logic [KW-1:0]     k_next;
    logic              idx_bad;
    logic [BYTE_W-1:0] bit_mask;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;

    bba_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign eff_count  = (i_block_count > CNT_W'(CAP)) ? CNT_W'(CAP) : i_block_count;
    assign scan_bytes = eff_count[CNT_W-1:3];
    assign scan_limit = (scan_bytes > KW'(SCAN_MAX)) ? KW'(SCAN_MAX) : scan_bytes;
    assign idx_bad    = ({1'b0, i_req.block_index} >= eff_count);
    assign k_next     = r_k + KW'(1);
    assign bit_mask   = 8'h80 >> r_bit;

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found_index = r_found;
    assign o_rsp.status      = r_status;

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_k          = r_k;
        n_limit      = r_limit;
        n_op         = r_op;
        n_bit        = r_bit;
        n_addr       = r_addr;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_found      = r_found;
        n_status     = r_status;
        wr_en        = 1'b0;
        wr_addr      = r_clr;
        wr_data      = '0;
        rd_addr      = AW'(r_k);

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op        = i_req.opcode;
                    n_bit       = i_req.block_index[2:0];
                    n_addr      = AW'(i_req.block_index[IDX_W-1:3]);
                    n_res_found = i_req.block_index;
                    case (i_req.opcode)
                        OP_FIND: begin
                            n_k          = '0;
                            n_limit      = scan_limit;
                            n_res_found  = '0;
                            n_res_status = ST_NONE;
                            rd_addr      = '0;
                            n_state      = (scan_limit == '0) ? S_RESP : S_FIND;
                        end
                        OP_SET, OP_CLR: begin
                            rd_addr = AW'(i_req.block_index[IDX_W-1:3]);
                            if (idx_bad) begin
                                n_res_status = ST_RANGE;
                                n_state      = S_RESP;
                            end else begin
                                n_res_status = ST_OK;
                                n_state      = S_UPD;
                            end
                        end
                        default: begin
                            n_res_status = ST_RANGE;
                            n_state      = S_RESP;
                        end
                    endcase
                end
            end
            S_FIND: begin
                // The read for the following byte is issued while this one is checked.
                rd_addr = AW'(k_next);
                if (rd_data != '1) begin
                    n_res_found  = IDX_W'({r_k, first_clear(rd_data)});
                    n_res_status = ST_OK;
                    n_state      = S_RESP;
                end else if (k_next == r_limit) begin
                    n_state = S_RESP;
                end else begin
                    n_k = k_next;
                end
            end
            S_UPD: begin
                wr_en   = 1'b1;
                wr_addr = r_addr;
                wr_data = (r_op == OP_SET) ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_found     = r_res_found;
                    n_status    = r_res_status;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_k          <= n_k;
        r_limit      <= n_limit;
        r_op         <= n_op;
        r_bit        <= n_bit;
        r_addr       <= n_addr;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        r_found      <= n_found;
        r_status     <= n_status;
    end

    a_write_only_clear_or_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_CLEAR || r_state == S_UPD))
        else $error("bitmap written outside clear pass or update");

    a_scan_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIND |-> r_k < r_limit)
        else $error("scan index reached the scan limit");

    a_update_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPD |-> $past(i_req.valid && i_req.ready))
        else $error("update without an accepted transaction");

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RESP))
        else $error("result presented without a finished request");

endmodule

[src/block_bitmap_allocator.sv]
// Free-block bitmap allocator. One bit per block, held as bytes in a synchronous RAM;
// bit 7 of byte k stands for block 8k, and a set bit means the block is in use.
// Requests arrive on i_req (valid/ready with opcode and block_index): find returns the
// lowest free block among the first block_count/8 bytes, set marks a block used and
// clear marks it free. Each request gives one transaction on o_rsp with found_index
// and status (ok, none free, or index out of range).
// block_count is written over the APB port at address 0 and reads back there.
// One request is worked on at a time. A set or clear reads its byte from the RAM, writes
// it back in the update state and passes to the response state. A rejected request, or a
// find with no bytes to scan, goes straight to the response state. A find reads one
// bitmap byte per cycle until it meets a byte with a clear bit or reaches the scan limit.
// The response state loads the output register, raising o_rsp.valid, and frees i_req for
// the next request at the same time.
// After reset the bitmap RAM is cleared one byte per cycle, all (MAX_BLOCKS+7)/8 bytes
// (128 by default), during which i_req.ready stays low; block_count returns to 1024.
// The result sits in an output register, so a new request is accepted while the
// receiver stalls; that request finishes and then waits until the register is taken.
module block_bitmap_allocator #(
    parameter int unsigned MAX_BLOCKS = bba_pkg::BBA_MAX_BLOCKS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bba_req_if.sink                    i_req,
    bba_rsp_if.source                  o_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bba_pkg::APB_AW-1:0] paddr,
    input  logic [bba_pkg::APB_DW-1:0] pwdata,
    output logic [bba_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import bba_pkg::*;

    logic [CNT_W-1:0] r_block_count;
    logic             reg_hit;

    // Registers sit on 4-byte steps, so the register index is the upper address bit.
    assign reg_hit = (paddr[APB_AW-1:2] == REG_BLOCK_COUNT[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= BLOCK_COUNT_RST;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_block_count <= pwdata[CNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_hit ? APB_DW'(r_block_count) : '0;

    bba_engine #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_block_count (r_block_count),
        .i_req         (i_req),
        .o_rsp         (o_rsp)
    );

endmodule
